// ===== rtl/pcgrng_pkg.sv =====
// pcgrng_pkg: constants, codes and helper functions shared by the random stream block
// no dependencies; imported by pcgrng_mul, pcgrng_rem and pcg32_lcg_bounded_random
`default_nettype none

package pcgrng_pkg;

  // generator constants
  localparam logic [63:0] PCG_MULT       = 64'd6364136223846793005;
  localparam logic [31:0] LCG_MULT       = 32'd196314165;
  localparam logic [31:0] LCG_ADD        = 32'd907633515;
  localparam logic [31:0] FRAC_MASK      = 32'h007f_ffff;
  localparam logic [63:0] PCG_STATE_INIT = 64'h853c_49e6_748f_ea9b;
  localparam logic [63:0] PCG_INC_INIT   = 64'hda3e_39cb_94b9_5bdb;

  // request codes
  localparam logic [2:0] FUNC_RESEED   = 3'd0;
  localparam logic [2:0] FUNC_RAW      = 3'd1;
  localparam logic [2:0] FUNC_URANGE   = 3'd2;
  localparam logic [2:0] FUNC_SRANGE   = 3'd3;
  localparam logic [2:0] FUNC_FRACTION = 3'd4;

  // register indexes
  localparam logic [1:0] REG_GEN_SELECT = 2'd0;
  localparam logic [1:0] REG_PCG_SEED   = 2'd1;
  localparam logic [1:0] REG_PCG_INC    = 2'd2;
  localparam logic [1:0] REG_LCG_SEED   = 2'd3;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LIMIT = 6'b000010,
    S_MUL   = 6'b000100,
    S_CHECK = 6'b001000,
    S_MOD   = 6'b010000,
    S_FIN   = 6'b100000
  } seq_state_t;

  // request to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // request to the remainder unit
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } rem_req_t;

  // xsh rr output permutation of the old pcg state
  function automatic logic [31:0] pcg_output(input logic [63:0] s);
    logic [63:0] xs;
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [4:0]  rot_l;
    xs    = ((s >> 18) ^ s) >> 27;
    mixed = xs[31:0];
    rot   = s[63:59];
    rot_l = 5'(5'd0 - rot);
    return (mixed >> rot) | (mixed << rot_l);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pcgrng_mul.sv =====
// pcgrng_mul: shared multiplier giving the low 64 bits of a 64 x 64 product
// one 32 x 32 multiplier used over four steps; depends on pcgrng_pkg
`default_nettype none

module pcgrng_mul
  import pcgrng_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire mul_req_t    req,
  output logic             done,
  output logic [63:0]      prod
);

  logic [63:0] a;
  logic [63:0] b;
  logic [1:0]  step;
  logic        busy;
  logic [63:0] pp;
  logic [63:0] acc;
  logic [31:0] ma;
  logic [31:0] mb;

  // operand halves for each partial product
  assign ma = (step == 2'd2) ? a[63:32] : a[31:0];
  assign mb = (step == 2'd1) ? b[63:32] : b[31:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= 2'(step + 2'd1);
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial product and accumulation
  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
    end else if (busy) begin
      pp <= ma * mb;
      case (step)
        2'd1:    acc <= pp;
        2'd2:    acc[63:32] <= 32'(acc[63:32] + pp[31:0]);
        2'd3:    acc[63:32] <= 32'(acc[63:32] + pp[31:0]);
        default: acc <= acc;
      endcase
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

// ===== rtl/pcgrng_rem.sv =====
// pcgrng_rem: 32-bit remainder unit, restoring, one quotient bit a cycle
// depends on pcgrng_pkg; divisor must be non-zero
`default_nettype none

module pcgrng_rem
  import pcgrng_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rem_req_t    req,
  output logic             done,
  output logic [31:0]      rem
);

  logic [31:0] dvd;
  logic [31:0] dsr;
  logic [4:0]  count;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] diff;

  // trial subtraction of the shifted partial remainder
  assign trial = {rem, dvd[31]};
  assign diff  = trial - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= 5'd31;
      end else if (busy) begin
        count <= 5'(count - 5'd1);
        if (count == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= 32'd0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      if (!diff[32]) begin
        rem <= diff[31:0];
      end else begin
        rem <= trial[31:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcg32_lcg_bounded_random.sv =====
// pcg32_lcg_bounded_random: random stream with pcg32 / 32-bit lcg and bounded draws
// depends on pcgrng_pkg, pcgrng_mul and pcgrng_rem

// One request item at a time: reseed, raw draw, unsigned or signed bounded
// draw, or 23-bit unit fraction. Each draw runs through one shared 32 x 32
// multiplier over four steps; bounded draws also use a one-bit-a-cycle
// remainder unit twice, once for the rejection limit and once for the final
// reduction, and a rejected draw is followed by a new draw. A finished value
// waits in the output register, so the next item is taken while it is still
// unread. Config is always ready and should only be written while no item
// is in flight.
`default_nettype none

module pcg32_lcg_bounded_random
  import pcgrng_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // request items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func,
  input  wire logic [31:0] min_value,
  input  wire logic [31:0] max_value,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      value,
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  seq_state_t  state;
  logic        gen_select;
  logic [63:0] pcg_seed_state;
  logic [63:0] pcg_increment;
  logic [31:0] lcg_seed;
  logic [63:0] pcg_state;
  logic [31:0] lcg_state;
  logic [2:0]  func_r;
  logic [31:0] base;
  logic [31:0] range;
  logic [31:0] limit;
  logic [31:0] draw_r;
  logic [31:0] result;

  logic        in_fire;
  logic [31:0] urange;
  logic [32:0] sdiff;
  logic        s_empty;
  logic [31:0] new_range;
  logic        go_bounded;
  logic [31:0] lcg_new;
  logic [63:0] pcg_new;
  logic [31:0] draw_val;
  logic        mul_done;
  logic [63:0] mul_prod;
  logic        rem_done;
  logic [31:0] rem_val;
  mul_req_t    mul_req;
  rem_req_t    rem_req;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // range set-up for bounded requests
  assign urange    = 32'(max_value - min_value);
  assign sdiff     = {max_value[31], max_value} - {min_value[31], min_value};
  assign s_empty   = sdiff[32] || (sdiff == 33'd0);
  assign new_range = (func == FUNC_SRANGE) ? sdiff[31:0] : urange;
  assign go_bounded = ((func == FUNC_URANGE) && (urange != 32'd0)) ||
                      ((func == FUNC_SRANGE) && !s_empty);

  // generator step from the multiplier product
  assign lcg_new  = 32'(mul_prod[31:0] + LCG_ADD);
  assign pcg_new  = 64'(mul_prod + (pcg_increment | 64'd1));
  assign draw_val = gen_select ? lcg_new : pcg_output(pcg_state);

  // multiplier request: new draw on raw or fraction, after the limit, or on rejection
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = gen_select ? {32'd0, lcg_state} : pcg_state;
    mul_req.b     = gen_select ? {32'd0, LCG_MULT} : PCG_MULT;
    case (state)
      S_IDLE:  mul_req.start = in_fire && ((func == FUNC_RAW) || (func == FUNC_FRACTION));
      S_LIMIT: mul_req.start = rem_done;
      S_CHECK: mul_req.start = ((func_r == FUNC_URANGE) || (func_r == FUNC_SRANGE)) &&
                               (draw_r < limit);
      default: mul_req.start = 1'b0;
    endcase
  end

  // remainder request: rejection limit at entry, final reduction after an accepted draw
  always_comb begin
    rem_req.start    = 1'b0;
    rem_req.dividend = draw_r;
    rem_req.divisor  = range;
    case (state)
      S_IDLE: begin
        rem_req.start    = in_fire && go_bounded;
        rem_req.dividend = 32'(32'd0 - new_range);
        rem_req.divisor  = new_range;
      end
      S_CHECK: begin
        rem_req.start = ((func_r == FUNC_URANGE) || (func_r == FUNC_SRANGE)) &&
                        (draw_r >= limit);
      end
      default: rem_req.start = 1'b0;
    endcase
  end

  pcgrng_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  pcgrng_rem u_rem (
    .clk  (clk),
    .rst  (rst),
    .req  (rem_req),
    .done (rem_done),
    .rem  (rem_val)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_select     <= 1'b0;
      pcg_seed_state <= PCG_STATE_INIT;
      pcg_increment  <= PCG_INC_INIT;
      lcg_seed       <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GEN_SELECT: gen_select     <= cfg_data[0];
        REG_PCG_SEED:   pcg_seed_state <= cfg_data;
        REG_PCG_INC:    pcg_increment  <= cfg_data;
        REG_LCG_SEED:   lcg_seed       <= cfg_data[31:0];
        default:        gen_select     <= gen_select;
      endcase
    end
  end

  // generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      pcg_state <= PCG_STATE_INIT;
      lcg_state <= 32'd0;
    end else if (in_fire && (func == FUNC_RESEED)) begin
      pcg_state <= pcg_seed_state;
      lcg_state <= lcg_seed;
    end else if ((state == S_MUL) && mul_done) begin
      if (gen_select) begin
        lcg_state <= lcg_new;
      end else begin
        pcg_state <= pcg_new;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // output register: loads from the finish state, clears once the item is taken
      if ((state == S_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (mul_req.start) begin
              state <= S_MUL;
            end else if (go_bounded) begin
              state <= S_LIMIT;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_LIMIT: begin
          if (rem_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (mul_req.start) begin
            state <= S_MUL;
          end else if (rem_req.start) begin
            state <= S_MOD;
          end else begin
            state <= S_FIN;
          end
        end
        S_MOD: begin
          if (rem_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item payload and working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          func_r <= func;
          base   <= min_value;
          range  <= new_range;
          // result for items that finish without a draw
          if ((func == FUNC_URANGE) || (func == FUNC_SRANGE)) begin
            result <= min_value;
          end else begin
            result <= 32'd0;
          end
        end
      end
      S_LIMIT: begin
        if (rem_done) begin
          limit <= rem_val;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          draw_r <= draw_val;
        end
      end
      S_CHECK: begin
        if (func_r == FUNC_FRACTION) begin
          result <= draw_r & FRAC_MASK;
        end else begin
          result <= draw_r;
        end
      end
      S_MOD: begin
        if (rem_done) begin
          result <= 32'(base + rem_val);
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          value <= result;
        end
      end
      default: result <= result;
    endcase
  end

endmodule

`default_nettype wire
